>>> src/mrqa_pkg.sv
// ----------------------------------------------------------------------------
// mrqa_pkg
// Shared types and codes for the memory request queue arbiter.
// ----------------------------------------------------------------------------
package mrqa_pkg;

    localparam int NUM_Q   = 5;
    localparam int Q_WRITE = 0;
    localparam int Q_READ  = 1;
    localparam int Q_FETCH = 2;
    localparam int Q_RDATA = 3;
    localparam int Q_FDATA = 4;

    typedef enum logic [2:0] {
        OP_PUSH_READ  = 3'd0,
        OP_PUSH_FETCH = 3'd1,
        OP_PUSH_WRITE = 3'd2,
        OP_POP_RDATA  = 3'd3,
        OP_POP_FDATA  = 3'd4,
        OP_SERVICE    = 3'd5,
        OP_RESPONSE   = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_FETCH = 2'd3
    } mem_cmd_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] req_address;
        logic [7:0]  req_mask;
        logic [31:0] req_wdata;
        logic [31:0] resp_data;
        logic        resp_ok;
    } item_t;

    typedef struct packed {
        logic        accepted;
        logic        pop_valid;
        logic [31:0] pop_word;
        logic [1:0]  mem_cmd;
        logic [31:0] mem_address;
        logic [7:0]  mem_mask;
        logic [31:0] mem_wdata;
        logic        read_data_empty;
        logic        fetch_data_empty;
        logic        write_full;
    } result_t;

    typedef struct packed {
        logic             capture;
        logic             exec;
        logic             load;
        logic [NUM_Q-1:0] push;
        logic [NUM_Q-1:0] pop;
        logic             accepted;
        logic             pop_valid;
        logic             pop_fetch;
        mem_cmd_t         mem_cmd;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [2:0]       op;
        logic [NUM_Q-1:0] empty;
        logic [NUM_Q-1:0] full;
    } dp_status_t;

endpackage

>>> src/mrqa_ram.sv
// ----------------------------------------------------------------------------
// mrqa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mrqa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> src/mrqa_datapath.sv
// ----------------------------------------------------------------------------
// mrqa_datapath
// Queue pointers, counts, entry stores and the result register.
// ----------------------------------------------------------------------------
module mrqa_datapath #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mrqa_pkg::item_t      item,
    input  mrqa_pkg::ctrl_cmd_t  cmd,
    output mrqa_pkg::dp_status_t status,
    output mrqa_pkg::result_t    result
);
    import mrqa_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [31:0] address;
        logic [7:0]  mask;
        logic [31:0] wdata;
    } wreq_t;

    item_t            item_reg;
    logic [PTR_W-1:0] head_reg [NUM_Q];
    logic [PTR_W-1:0] tail_reg [NUM_Q];
    logic [CNT_W-1:0] count_reg [NUM_Q];
    logic             accepted_reg;
    logic             pop_valid_reg;
    logic             pop_fetch_reg;
    mem_cmd_t         kind_reg;
    result_t          result_reg;
    result_t          result_next;

    wreq_t            wreq_wr;
    wreq_t            wreq_rd;
    logic [31:0]      raddr_rd;
    logic [31:0]      faddr_rd;
    logic [31:0]      rword_rd;
    logic [31:0]      fword_rd;
    logic [31:0]      resp_word;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_Q; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_Q; i++)
            begin
                if (cmd.push[i])
                begin
                    tail_reg[i]  <= next_slot(tail_reg[i]);
                    count_reg[i] <= count_reg[i] + 1'b1;
                end
                else if (cmd.pop[i])
                begin
                    head_reg[i]  <= next_slot(head_reg[i]);
                    count_reg[i] <= count_reg[i] - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= item;
        end
        if (cmd.exec)
        begin
            accepted_reg  <= cmd.accepted;
            pop_valid_reg <= cmd.pop_valid;
            pop_fetch_reg <= cmd.pop_fetch;
            kind_reg      <= cmd.mem_cmd;
        end
        if (cmd.load)
        begin
            result_reg <= result_next;
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_Q; i++)
        begin
            status.empty[i] = (count_reg[i] == '0);
            status.full[i]  = (count_reg[i] == CNT_W'(QUEUE_DEPTH));
        end
        status.op = item_reg.op;
    end

    assign wreq_wr.address = item_reg.req_address;
    assign wreq_wr.mask    = item_reg.req_mask;
    assign wreq_wr.wdata   = item_reg.req_wdata;
    assign resp_word       = item_reg.resp_ok ? item_reg.resp_data : 32'd0;

    mrqa_ram #(.WIDTH($bits(wreq_t)), .DEPTH(QUEUE_DEPTH)) u_write_ram (
        .clk     (clk),
        .wr_en   (cmd.push[Q_WRITE]),
        .wr_addr (tail_reg[Q_WRITE]),
        .wr_data (wreq_wr),
        .rd_en   (cmd.pop[Q_WRITE]),
        .rd_addr (head_reg[Q_WRITE]),
        .rd_data (wreq_rd)
    );

    mrqa_ram #(.WIDTH(32), .DEPTH(QUEUE_DEPTH)) u_read_ram (
        .clk     (clk),
        .wr_en   (cmd.push[Q_READ]),
        .wr_addr (tail_reg[Q_READ]),
        .wr_data (item_reg.req_address),
        .rd_en   (cmd.pop[Q_READ]),
        .rd_addr (head_reg[Q_READ]),
        .rd_data (raddr_rd)
    );

    mrqa_ram #(.WIDTH(32), .DEPTH(QUEUE_DEPTH)) u_fetch_ram (
        .clk     (clk),
        .wr_en   (cmd.push[Q_FETCH]),
        .wr_addr (tail_reg[Q_FETCH]),
        .wr_data (item_reg.req_address),
        .rd_en   (cmd.pop[Q_FETCH]),
        .rd_addr (head_reg[Q_FETCH]),
        .rd_data (faddr_rd)
    );

    mrqa_ram #(.WIDTH(32), .DEPTH(QUEUE_DEPTH)) u_rdata_ram (
        .clk     (clk),
        .wr_en   (cmd.push[Q_RDATA]),
        .wr_addr (tail_reg[Q_RDATA]),
        .wr_data (resp_word),
        .rd_en   (cmd.pop[Q_RDATA]),
        .rd_addr (head_reg[Q_RDATA]),
        .rd_data (rword_rd)
    );

    mrqa_ram #(.WIDTH(32), .DEPTH(QUEUE_DEPTH)) u_fdata_ram (
        .clk     (clk),
        .wr_en   (cmd.push[Q_FDATA]),
        .wr_addr (tail_reg[Q_FDATA]),
        .wr_data (resp_word),
        .rd_en   (cmd.pop[Q_FDATA]),
        .rd_addr (head_reg[Q_FDATA]),
        .rd_data (fword_rd)
    );

    always_comb
    begin
        result_next                  = '0;
        result_next.accepted         = accepted_reg;
        result_next.pop_valid        = pop_valid_reg;
        result_next.mem_cmd          = kind_reg;
        result_next.read_data_empty  = status.empty[Q_RDATA];
        result_next.fetch_data_empty = status.empty[Q_FDATA];
        result_next.write_full       = status.full[Q_WRITE];
        if (pop_valid_reg)
        begin
            result_next.pop_word = pop_fetch_reg ? fword_rd : rword_rd;
        end
        unique case (kind_reg)
            CMD_WRITE:
            begin
                result_next.mem_address = wreq_rd.address;
                result_next.mem_mask    = wreq_rd.mask;
                result_next.mem_wdata   = wreq_rd.wdata;
            end
            CMD_READ:  result_next.mem_address = raddr_rd;
            CMD_FETCH: result_next.mem_address = faddr_rd;
            default:   result_next.mem_address = '0;
        endcase
    end

    assign result = result_reg;

    for (genvar g = 0; g < NUM_Q; g++)
    begin : g_chk
        a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
            count_reg[g] <= CNT_W'(QUEUE_DEPTH))
            else $error("queue count above depth");
        a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
            cmd.push[g] |-> !status.full[g])
            else $error("push into full queue");
    end

endmodule

>>> src/mrqa_ctrl.sv
// ----------------------------------------------------------------------------
// mrqa_ctrl
// Sequencer: takes a word, decides the queue action, loads the result.
// ----------------------------------------------------------------------------
module mrqa_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    output logic                 result_valid,
    input  logic                 result_ready,
    input  mrqa_pkg::dp_status_t status,
    output mrqa_pkg::ctrl_cmd_t  cmd
);
    import mrqa_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD
    } state_t;

    typedef enum logic [1:0] {
        AW_NONE,
        AW_READ,
        AW_FETCH
    } await_t;

    state_t     state_reg;
    state_t     state_next;
    await_t     await_reg;
    await_t     await_next;
    logic       result_valid_reg;
    logic       result_valid_next;
    logic       out_free;
    ctrl_cmd_t  act;

    assign out_free   = !result_valid_reg || result_ready;
    assign item_ready = (state_reg == S_IDLE);

    always_comb
    begin
        act        = '0;
        await_next = await_reg;
        unique case (op_t'(status.op))
            OP_PUSH_READ:
            begin
                act.push[Q_READ] = !status.full[Q_READ];
                act.accepted     = !status.full[Q_READ];
            end
            OP_PUSH_FETCH:
            begin
                act.push[Q_FETCH] = !status.full[Q_FETCH];
                act.accepted      = !status.full[Q_FETCH];
            end
            OP_PUSH_WRITE:
            begin
                act.push[Q_WRITE] = !status.full[Q_WRITE];
                act.accepted      = !status.full[Q_WRITE];
            end
            OP_POP_RDATA:
            begin
                act.pop[Q_RDATA] = !status.empty[Q_RDATA];
                act.pop_valid    = !status.empty[Q_RDATA];
            end
            OP_POP_FDATA:
            begin
                act.pop[Q_FDATA] = !status.empty[Q_FDATA];
                act.pop_valid    = !status.empty[Q_FDATA];
                act.pop_fetch    = 1'b1;
            end
            OP_SERVICE:
            begin
                if (await_reg == AW_NONE)
                begin
                    priority if (!status.empty[Q_WRITE])
                    begin
                        act.pop[Q_WRITE] = 1'b1;
                        act.mem_cmd      = CMD_WRITE;
                    end
                    else if (!status.empty[Q_READ] && !status.full[Q_RDATA])
                    begin
                        act.pop[Q_READ] = 1'b1;
                        act.mem_cmd     = CMD_READ;
                        await_next      = AW_READ;
                    end
                    else if (!status.empty[Q_FETCH] && !status.full[Q_FDATA])
                    begin
                        act.pop[Q_FETCH] = 1'b1;
                        act.mem_cmd      = CMD_FETCH;
                        await_next       = AW_FETCH;
                    end
                    else
                    begin
                        act.mem_cmd = CMD_NONE;
                    end
                end
            end
            OP_RESPONSE:
            begin
                act.push[Q_RDATA] = (await_reg == AW_READ) && !status.full[Q_RDATA];
                act.push[Q_FDATA] = (await_reg == AW_FETCH) && !status.full[Q_FDATA];
                await_next        = AW_NONE;
            end
            default:
            begin
                act = '0;
            end
        endcase
    end

    always_comb
    begin
        cmd               = '0;
        state_next        = state_reg;
        result_valid_next = result_valid_reg && !result_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.capture = item_valid;
                if (item_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd      = act;
                cmd.exec = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (out_free)
                begin
                    cmd.load          = 1'b1;
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            await_reg        <= AW_NONE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            if (state_reg == S_EXEC)
            begin
                await_reg <= await_next;
            end
        end
    end

    assign result_valid = result_valid_reg;

    a_one_queue_op: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.push, cmd.pop}))
        else $error("more than one queue touched");

    a_issue_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mem_cmd != CMD_NONE) |-> (await_reg == AW_NONE))
        else $error("command issued while awaiting response");

    a_await_set: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && (cmd.mem_cmd == CMD_READ || cmd.mem_cmd == CMD_FETCH))
        |=> (await_reg != AW_NONE))
        else $error("read or fetch issued without awaiting");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> out_free)
        else $error("result register overwritten");

endmodule

>>> src/memory_request_queue_arbiter.sv
// ----------------------------------------------------------------------------
// memory_request_queue_arbiter
// Three request queues and two response queues in front of a memory port,
// with fixed-priority issue: write, then data read, then fetch.
// ----------------------------------------------------------------------------
// The sequencer walks capture, queue update with RAM read, and result load;
//   it takes no new word until the result of the last one is loaded, and
//   the load waits while an earlier result has not been taken.
// Reset: all queues empty, no response awaited; entry RAMs are not cleared.
module memory_request_queue_arbiter #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  mrqa_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output mrqa_pkg::result_t result
);
    import mrqa_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    mrqa_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .cmd          (cmd)
    );

    mrqa_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

endmodule
